// ===== design/lcg_ranged_random_top_assert.svh =====
// Assertion macros shared by the checker of the ranged random generator.
`ifndef LCG_RANGED_RANDOM_TOP_ASSERT_SVH
`define LCG_RANGED_RANDOM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCGRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcgrr assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LCGRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcgrr assertion failed");

`endif

// ===== design/lcgrr_pkg.sv =====
// Package with the widths, generator constants and chain record of the ranged generator.
package lcgrr_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NUM_CELLS = SAMPLE_W;
  localparam int unsigned PART_W   = SAMPLE_W + 1;

  localparam logic [DATA_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [DATA_W-1:0] LCG_ADD = 32'd2531011;

  typedef struct packed {
    logic                valid;
    logic                err;
    logic [DATA_W-1:0]   lo;
    logic [DATA_W-1:0]   span;
    logic [SAMPLE_W-1:0] dividend;
    logic [SAMPLE_W-1:0] rem;
    logic [DATA_W-1:0]   state;
  } cell_t;

endpackage

// ===== design/lcgrr_req_if.sv =====
// Request channel carrying the signed bounds of one draw.
interface lcgrr_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcgrr_pkg::DATA_W-1:0] range_low;
  logic signed [lcgrr_pkg::DATA_W-1:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink (input valid, input range_low, input range_high, output ready);
endinterface

// ===== design/lcgrr_rsp_if.sv =====
// Response channel carrying the drawn value, the span error and the new state.
interface lcgrr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcgrr_pkg::DATA_W-1:0] random_value;
  logic                                span_error;
  logic        [lcgrr_pkg::DATA_W-1:0] state_after;

  modport source (output valid, output random_value, output span_error, output state_after,
                  input ready);
  modport sink (input valid, input random_value, input span_error, input state_after,
                output ready);
endinterface

// ===== design/lcgrr_gen.sv =====
// Generator state, seed load and the entry stage that feeds the divider chain.
module lcgrr_gen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         req_valid_i,
  input  logic [lcgrr_pkg::DATA_W-1:0] range_low_i,
  input  logic [lcgrr_pkg::DATA_W-1:0] range_high_i,
  input  logic                         cfg_we_i,
  input  logic [lcgrr_pkg::DATA_W-1:0] cfg_data_i,
  output lcgrr_pkg::cell_t             cell_o
);

  logic [lcgrr_pkg::DATA_W-1:0] gen_state_q, gen_state_d;
  logic [lcgrr_pkg::DATA_W-1:0] state_next;
  logic [lcgrr_pkg::DATA_W-1:0] span;
  logic                         take;
  lcgrr_pkg::cell_t             cell_q, cell_d;

  assign state_next = gen_state_q * lcgrr_pkg::LCG_MUL + lcgrr_pkg::LCG_ADD;
  assign span       = range_high_i - range_low_i + {{(lcgrr_pkg::DATA_W-1){1'b0}}, 1'b1};
  assign take       = en_i && req_valid_i;

  always_comb begin
    gen_state_d = gen_state_q;
    if (cfg_we_i) begin
      gen_state_d = cfg_data_i;
    end else if (take) begin
      gen_state_d = state_next;
    end
  end

  always_comb begin
    cell_d.valid    = req_valid_i;
    cell_d.err      = (span == '0);
    cell_d.lo       = range_low_i;
    cell_d.span     = span;
    cell_d.dividend = state_next[lcgrr_pkg::DATA_W-1 -: lcgrr_pkg::SAMPLE_W];
    cell_d.rem      = '0;
    cell_d.state    = state_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_state_q <= '0;
      cell_q      <= '0;
    end else begin
      gen_state_q <= gen_state_d;
      if (en_i) begin
        cell_q <= cell_d;
      end
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== design/lcgrr_cell.sv =====
// One restoring division step that brings in the next sample bit and passes the record on.
module lcgrr_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  lcgrr_pkg::cell_t cell_i,
  output lcgrr_pkg::cell_t cell_o
);

  logic [lcgrr_pkg::PART_W-1:0] partial;
  logic [lcgrr_pkg::DATA_W-1:0] partial_ext;
  logic [lcgrr_pkg::DATA_W-1:0] diff;
  logic                         fits;
  lcgrr_pkg::cell_t             cell_q, cell_d;

  assign partial     = {cell_i.rem, cell_i.dividend[lcgrr_pkg::SAMPLE_W-1]};
  assign partial_ext = {{(lcgrr_pkg::DATA_W-lcgrr_pkg::PART_W){1'b0}}, partial};
  assign diff        = partial_ext - cell_i.span;
  assign fits        = (partial_ext >= cell_i.span);

  always_comb begin
    cell_d          = cell_i;
    cell_d.dividend = {cell_i.dividend[lcgrr_pkg::SAMPLE_W-2:0], 1'b0};
    cell_d.rem      = fits ? diff[lcgrr_pkg::SAMPLE_W-1:0] : partial[lcgrr_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== design/lcg_ranged_random_top.sv =====
// Top level of the ranged linear congruential generator with its divider chain.
//
//   Channel   Direction   Payload
//   req_i     in          range_low, range_high
//   rsp_o     out         random_value, span_error, state_after
//   cfg       in          cfg_data_i (seed), written when cfg_we_i is high
//
// A request passes through one entry stage, one cell for each of the 16 sample bits, and the
// output register. The chain takes a new request every cycle while no result waits stalled.
// Reset clears the generator state to zero and empties the chain.
// While a result waits at the output, the whole chain and the request side stall together.
module lcg_ranged_random_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcgrr_pkg::DATA_W-1:0] cfg_data_i,
  lcgrr_req_if.sink                    req_i,
  lcgrr_rsp_if.source                  rsp_o
);

  logic                         advance;
  lcgrr_pkg::cell_t             chain [lcgrr_pkg::NUM_CELLS+1];
  lcgrr_pkg::cell_t             last;
  logic                         rsp_valid_q;
  logic [lcgrr_pkg::DATA_W-1:0] value_q, value_d;
  logic                         err_q;
  logic [lcgrr_pkg::DATA_W-1:0] state_q;

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = advance;

  lcgrr_gen u_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .req_valid_i  (req_i.valid),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .cell_o       (chain[0])
  );

  for (genvar g = 0; g < lcgrr_pkg::NUM_CELLS; g++) begin : g_cell
    lcgrr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign last    = chain[lcgrr_pkg::NUM_CELLS];
  assign value_d = last.err ? '0
                 : last.lo + {{(lcgrr_pkg::DATA_W-lcgrr_pkg::SAMPLE_W){1'b0}}, last.rem};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q <= value_d;
      err_q   <= last.err;
      state_q <= last.state;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.random_value = value_q;
  assign rsp_o.span_error   = err_q;
  assign rsp_o.state_after  = state_q;

endmodule

// ===== design/lcgrr_checker.sv =====
// Port-level checker for the ranged generator and its binding to the top level.
`include "lcg_ranged_random_top_assert.svh"

module lcgrr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [lcgrr_pkg::DATA_W-1:0] random_value_i,
  input logic                         span_error_i,
  input logic [lcgrr_pkg::DATA_W-1:0] state_after_i
);

  `LCGRR_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(random_value_i) && $stable(span_error_i) && $stable(state_after_i))
  `LCGRR_ASSERT_NOW(a_err_zero, rsp_valid_i && span_error_i, random_value_i == '0)
  `LCGRR_ASSERT_NOW(a_ready_when_empty, !rsp_valid_i, req_ready_i)
  `LCGRR_ASSERT_NOW(a_stall_blocks_req, rsp_valid_i && !rsp_ready_i, !(req_valid_i && req_ready_i))

endmodule

bind lcg_ranged_random_top lcgrr_checker u_lcgrr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .random_value_i (rsp_o.random_value),
  .span_error_i   (rsp_o.span_error),
  .state_after_i  (rsp_o.state_after)
);
